// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked at every rising clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle that requires a consequence in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/xkb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the XOR-key base64 codec.
// Used by the front, queue, back and top-level modules; depends on nothing.
package xkb_pkg;

  localparam int KEY_BYTES   = 16;
  localparam int KEY_POS_W   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_KEY_LEN  = 2'd1;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd2;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_COUNT = 2'd1;
  localparam logic [1:0] ERR_PADS  = 2'd2;

  // Up to four results caused by one input item.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      n;
    logic            status;
    logic [1:0]      err;
    logic            last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/xkb_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, input acceptance, key XOR and base64 grouping.
// Produces at most one job per accepted item into the queue; depends on xkb_pkg.
module xkb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_write_en,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             in_msg_end,
  input  xkb_pkg::q_stat_t q_stat,
  output logic             push,
  output xkb_pkg::job_t    job
);

  typedef struct packed {
    logic       ok;
    logic       pad;
    logic [5:0] val;
  } sym_t;

  localparam logic [4:0] KEY_LEN_MAX = 5'(xkb_pkg::KEY_BYTES);

  logic                         mode_r, mode_nxt;
  logic [4:0]                   key_len_r, key_len_nxt;
  logic [63:0]                  key_low_r, key_low_nxt;
  logic [63:0]                  key_high_r, key_high_nxt;
  logic [xkb_pkg::KEY_POS_W-1:0] key_pos_r, key_pos_nxt;
  logic [7:0]                   store_r [3];
  logic [7:0]                   store_nxt [3];
  logic [1:0]                   fill_r, fill_nxt;
  logic [1:0]                   sym_cnt_r, sym_cnt_nxt;
  logic                         seen_r, seen_nxt;
  logic [1:0]                   pad_cnt_r, pad_cnt_nxt;
  logic                         stopped_r, stopped_nxt;
  logic                         pad_err_r, pad_err_nxt;

  logic                         accept;
  logic [4:0]                   len;
  logic [xkb_pkg::KEY_POS_W-1:0] p0, p1, p2, p3;
  logic [7:0]                   key_bytes [xkb_pkg::KEY_BYTES];
  sym_t                         sym;
  logic [1:0]                   f;
  logic [7:0]                   x, s0, s1, s2;
  logic [7:0]                   db0, db1, db2;
  logic [1:0]                   pc;
  logic [1:0]                   keep;
  logic [1:0]                   cnt_new;
  logic                         err_pads;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      b64_char = w + 8'd65;
    else if (v < 6'd52) b64_char = w + 8'd71;
    else if (v < 6'd62) b64_char = w - 8'd4;
    else if (v == 6'd62) b64_char = 8'h2B;
    else                b64_char = 8'h2F;
  endfunction

  function automatic sym_t classify(input logic [7:0] c);
    sym_t s;
    s = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.ok = 1'b1; s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.ok = 1'b1; s.val = 6'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.ok = 1'b1; s.val = 6'(c + 8'd4);
    end else if (c == 8'h2B) begin
      s.ok = 1'b1; s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.ok = 1'b1; s.val = 6'd63;
    end else if (c == 8'h3D) begin
      s.ok = 1'b1; s.pad = 1'b1;
    end
    return s;
  endfunction

  function automatic logic [xkb_pkg::KEY_POS_W-1:0] next_pos(
    input logic [xkb_pkg::KEY_POS_W-1:0] p, input logic [4:0] l);
    if ({1'b0, p} + 5'd1 >= l) next_pos = '0;
    else                       next_pos = p + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_bytes[i]     = key_low_r[i*8 +: 8];
      key_bytes[i + 8] = key_high_r[i*8 +: 8];
    end
  end

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  assign len = (key_len_r == 5'd0) ? 5'd1 : (key_len_r > KEY_LEN_MAX) ? KEY_LEN_MAX : key_len_r;
  assign p0  = ({1'b0, key_pos_r} >= len) ? '0 : key_pos_r;
  assign p1  = next_pos(p0, len);
  assign p2  = next_pos(p1, len);
  assign p3  = next_pos(p2, len);
  assign sym = classify(in_byte);

  // Encode operands: the fresh byte lands in the group slot given by the fill level.
  assign f  = (fill_r == 2'd3) ? 2'd0 : fill_r;
  assign x  = in_byte ^ key_bytes[p0];
  assign s0 = (f == 2'd0) ? x : store_r[0];
  assign s1 = (f == 2'd1) ? x : (f == 2'd2) ? store_r[1] : 8'h00;
  assign s2 = (f == 2'd2) ? x : 8'h00;

  // Decode operands: the fourth symbol completes the group.
  assign db0 = {store_r[0][5:0], store_r[1][5:4]};
  assign db1 = {store_r[1][3:0], store_r[2][5:2]};
  assign db2 = {store_r[2][1:0], sym.val};
  assign pc  = (sym.pad && pad_cnt_r != 2'd3) ? pad_cnt_r + 2'd1 : pad_cnt_r;
  assign keep = 2'd3 - pc;

  always_comb begin
    mode_nxt     = mode_r;
    key_len_nxt  = key_len_r;
    key_low_nxt  = key_low_r;
    key_high_nxt = key_high_r;
    key_pos_nxt  = key_pos_r;
    store_nxt    = store_r;
    fill_nxt     = fill_r;
    sym_cnt_nxt  = sym_cnt_r;
    seen_nxt     = seen_r;
    pad_cnt_nxt  = pad_cnt_r;
    stopped_nxt  = stopped_r;
    pad_err_nxt  = pad_err_r;
    cnt_new      = sym_cnt_r;
    err_pads     = pad_err_r;
    job          = '0;
    push         = 1'b0;

    if (accept) begin
      if (!mode_r) begin
        key_pos_nxt  = p1;
        store_nxt[f] = x;
        fill_nxt     = f + 2'd1;
        if (f == 2'd2 || in_msg_end) begin
          job.data[0] = b64_char(s0[7:2]);
          job.data[1] = b64_char({s0[1:0], s1[7:4]});
          job.data[2] = (f != 2'd0) ? b64_char({s1[3:0], s2[7:6]}) : 8'h3D;
          job.data[3] = (f == 2'd2) ? b64_char(s2[5:0]) : 8'h3D;
          job.n       = 3'd4;
          job.last    = in_msg_end;
          fill_nxt    = 2'd0;
          push        = 1'b1;
        end
      end else begin
        if (sym.ok) begin
          seen_nxt    = 1'b1;
          cnt_new     = sym_cnt_r + 2'd1;
          sym_cnt_nxt = cnt_new;
          if (!stopped_r) begin
            pad_cnt_nxt = pc;
            if (fill_r != 2'd3) begin
              store_nxt[fill_r] = {2'b00, sym.val};
              fill_nxt          = fill_r + 2'd1;
            end else begin
              job.data[0] = db0 ^ key_bytes[p0];
              job.data[1] = db1 ^ key_bytes[p1];
              job.data[2] = db2 ^ key_bytes[p2];
              job.n       = {1'b0, keep};
              case (keep)
                2'd1:    key_pos_nxt = p1;
                2'd2:    key_pos_nxt = p2;
                2'd3:    key_pos_nxt = p3;
                default: key_pos_nxt = key_pos_r;
              endcase
              if (pc == 2'd3) begin
                pad_err_nxt = 1'b1;
                err_pads    = 1'b1;
              end
              if (pc != 2'd0) stopped_nxt = 1'b1;
              fill_nxt    = 2'd0;
              pad_cnt_nxt = 2'd0;
            end
          end
        end
        if (in_msg_end) begin
          job.status = 1'b1;
          job.last   = 1'b1;
          job.n      = job.n + 3'd1;
          if (!(seen_r || sym.ok) || cnt_new != 2'd0) job.err = xkb_pkg::ERR_COUNT;
          else if (err_pads)                          job.err = xkb_pkg::ERR_PADS;
          else                                        job.err = xkb_pkg::ERR_NONE;
        end
        push = (job.n != 3'd0);
      end
      if (in_msg_end) begin
        key_pos_nxt = '0;
        fill_nxt    = 2'd0;
        sym_cnt_nxt = 2'd0;
        seen_nxt    = 1'b0;
        pad_cnt_nxt = 2'd0;
        stopped_nxt = 1'b0;
        pad_err_nxt = 1'b0;
      end
    end

    if (cfg_write_en) begin
      case (cfg_index)
        xkb_pkg::CFG_MODE: begin
          // A mode change abandons any message in progress.
          mode_nxt    = cfg_data[0];
          key_pos_nxt = '0;
          fill_nxt    = 2'd0;
          sym_cnt_nxt = 2'd0;
          seen_nxt    = 1'b0;
          pad_cnt_nxt = 2'd0;
          stopped_nxt = 1'b0;
          pad_err_nxt = 1'b0;
        end
        xkb_pkg::CFG_KEY_LEN:  key_len_nxt  = cfg_data[4:0];
        xkb_pkg::CFG_KEY_LOW:  key_low_nxt  = cfg_data;
        xkb_pkg::CFG_KEY_HIGH: key_high_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      key_len_r  <= 5'd1;
      key_low_r  <= '0;
      key_high_r <= '0;
      key_pos_r  <= '0;
      fill_r     <= 2'd0;
      sym_cnt_r  <= 2'd0;
      seen_r     <= 1'b0;
      pad_cnt_r  <= 2'd0;
      stopped_r  <= 1'b0;
      pad_err_r  <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      key_len_r  <= key_len_nxt;
      key_low_r  <= key_low_nxt;
      key_high_r <= key_high_nxt;
      key_pos_r  <= key_pos_nxt;
      fill_r     <= fill_nxt;
      sym_cnt_r  <= sym_cnt_nxt;
      seen_r     <= seen_nxt;
      pad_cnt_r  <= pad_cnt_nxt;
      stopped_r  <= stopped_nxt;
      pad_err_r  <= pad_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule

// ===== rtl/xkb_queue.sv =====
`timescale 1ns / 1ps
// Small job queue between the front and back ends of the codec.
// Holds QUEUE_DEPTH jobs in registers; depends on xkb_pkg.
module xkb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xkb_pkg::job_t    push_job,
  input  logic             pop,
  output xkb_pkg::job_t    head,
  output xkb_pkg::q_stat_t stat
);

  xkb_pkg::job_t                 slots_r [xkb_pkg::QUEUE_DEPTH];
  logic [xkb_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [xkb_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [xkb_pkg::QPTR_W:0]      count_r, count_nxt;

  assign stat.full  = (count_r == (xkb_pkg::QPTR_W + 1)'(xkb_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/xkb_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the results of the head job, one per cycle while out_stall is low,
// into the output register. Depends on xkb_pkg for the job and queue status types.
module xkb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  xkb_pkg::job_t    head,
  input  xkb_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic [1:0]       out_error_code,
  output logic             out_run_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       has_r;
  logic [1:0] err_r;
  logic       last_r;
  logic       load;
  logic       final_one;

  // The output register may be refilled when empty or when its result transfers.
  assign load      = !q_stat.empty && (!valid_r || !out_stall);
  assign final_one = ({1'b0, idx_r} + 3'd1 == head.n);
  assign pop       = load && final_one;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = final_one ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.status && final_one) begin
        byte_r <= 8'h00;
        has_r  <= 1'b0;
        err_r  <= head.err;
      end else begin
        byte_r <= head.data[idx_r];
        has_r  <= 1'b1;
        err_r  <= xkb_pkg::ERR_NONE;
      end
      last_r <= head.last && final_one;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_has_byte   = has_r;
  assign out_error_code = err_r;
  assign out_run_last   = last_r;

endmodule

// ===== rtl/xor_key_base64_codec_core.sv =====
`timescale 1ns / 1ps
// Byte-stream codec: repeating-key XOR combined with base64 encode or decode.
// Top level; instantiates xkb_front, xkb_queue and xkb_back, uses xkb_pkg.
//
// One input byte can be taken in every clock while the four-entry job queue has
// room; each byte yields zero to four results, and the back end sends one result
// per clock through its output register while out_stall is low. Sustained
// throughput is therefore set by the result channel: four characters for every
// three bytes when encoding, at most one result per byte when decoding, plus the
// status result at each message end when decoding. A result is registered in the
// job queue and then in the output register before it is offered. Configuration
// is written through cfg_write_en, cfg_index (0 mode, 1 key length, 2 key bytes
// 0..7, 3 key bytes 8..15) and cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce; a mode write also
// abandons any message in progress. There is no clearing pass after reset.
module xor_key_base64_codec_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_msg_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic [1:0]  out_error_code,
  output logic        out_run_last
);

  xkb_pkg::job_t    push_job;
  xkb_pkg::job_t    head_job;
  xkb_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  xkb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_msg_end   (in_msg_end),
    .q_stat       (q_stat),
    .push         (push),
    .job          (push_job)
  );

  xkb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .stat     (q_stat)
  );

  xkb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head_job),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_error_code (out_error_code),
    .out_run_last   (out_run_last)
  );

endmodule

// ===== rtl/xkb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the codec's result channel, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module xkb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_has_byte,
  input logic [1:0] out_error_code,
  input logic       out_run_last
);

  // A waiting result stays offered until it transfers.
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result withdrawn while stalled")
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_byte), "stalled result changed")
  // A status-only result always closes its message.
  `ASSERT_CLK(a_status_last, out_valid && !out_has_byte |-> out_run_last, "status result not last")
  // Error codes only ever travel on the closing status result.
  `ASSERT_CLK(a_err_status, out_valid && out_error_code != 2'd0 |-> out_run_last && !out_has_byte,
              "error code on a data result")
  `ASSERT_CLK(a_err_range, out_valid |-> out_error_code != 2'd3, "undefined error code")

endmodule

bind xor_key_base64_codec_core xkb_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_has_byte   (out_has_byte),
  .out_error_code (out_error_code),
  .out_run_last   (out_run_last)
);
